// ----- src/gaussian_kde_3d_assert.svh -----
// Assertion helpers for the KDE block.
`ifndef GAUSSIAN_KDE_3D_ASSERT_SVH
`define GAUSSIAN_KDE_3D_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define GKDE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GKDE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/gkde_pkg.sv -----
package gkde_pkg;

  localparam int MAX_POINTS_DEF  = 4096;
  localparam int EXP_ENTRIES_DEF = 1024;

  localparam int IDX_W   = 12;
  localparam int COORD_W = 8;
  localparam int DENS_W  = 48;
  localparam int NUM_W   = 13;
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 4;
  localparam int QDEPTH  = 4;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_BAD   = 2'd2;

  localparam logic [1:0] REG_NUM_POINTS = 2'd0;
  localparam logic [1:0] REG_EXP_SCALE  = 2'd1;
  localparam logic [1:0] REG_NORM       = 2'd2;

  localparam logic [NUM_W-1:0] NUM_POINTS_RST = 13'd4096;
  localparam logic [CFG_W-1:0] EXP_SCALE_RST  = 32'd48408924;
  localparam logic [CFG_W-1:0] NORM_RST       = 32'd33296;

  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   point_index;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  queried_index;
    logic [DENS_W-1:0] density;
    logic              bad_index;
  } out_item_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [IDX_W-1:0]     index;
    logic [3*COORD_W-1:0] point;
  } cmd_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // 2^-(q/2^32) in Q1.32 by products of repeated square roots of one half
  function automatic logic [32:0] exp_frac(input logic [31:0] q);
    logic [63:0]  c [32];
    logic [127:0] acc;
    c[0] = isqrt64(64'h8000_0000_0000_0000);
    for (int k = 1; k < 32; k++) c[k] = isqrt64(c[k-1] << 32);
    acc = 128'd1 << 32;
    for (int k = 0; k < 32; k++) begin
      if (q[31-k]) acc = (acc * {64'd0, c[k]} + (128'd1 << 31)) >> 32;
    end
    return acc[32:0];
  endfunction

endpackage

// ----- src/gaussian_kde_3d.sv -----
// Gaussian kernel density estimator over up to MAX_POINTS stored 8-bit 3-D points.
// Request channel: push/full. mode 0 stores (x,y,z) at point_index; mode 1 asks
// for the density at stored point point_index. Loads give no transaction out.
// Result channel: empty/pop; one transaction per query with the index, the
// Q16.32 density and a bad_index flag (index at or above the point count).
// Config: APB writes to num_points (0x0), exponent_scale (0x4), norm_factor (0x8);
// the user must write only while no request is in flight, as the block does not
// enforce it. After reset the kernel table is loaded with full held high;
// registers take their defaults, stored points are undefined until loaded.
// A four-entry command queue sits between intake and the compute engine, and a
// result register sits at the output, so requests keep flowing while a result waits.
// A load leaves the queue once the engine is idle, a bad query once the result
// register is free. A good query runs from acceptance to result through queue pop,
// point fetch, N point-memory reads, the kernel pipeline tail, a 1-bit-per-cycle
// divide of 33 + clog2(MAX_POINTS+1) steps and the S_MUL and S_FIN scale states.
// One point memory read port paces the N reads. One query is worked at a time.
// If pop stays low, the engine halts at its finished result and the queue fills.
module gaussian_kde_3d import gkde_pkg::*; #(
  parameter int MAX_POINTS        = MAX_POINTS_DEF,
  parameter int EXP_TABLE_ENTRIES = EXP_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  in_item_t           request,
  output logic               empty,
  input  logic               pop,
  output out_item_t          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [NUM_W-1:0] num_points;
  logic [CFG_W-1:0] exponent_scale;
  logic [CFG_W-1:0] norm_factor;
  logic [CNT_W-1:0] n_eff;
  logic             busy;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points     <= NUM_POINTS_RST;
      exponent_scale <= EXP_SCALE_RST;
      norm_factor    <= NORM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_NUM_POINTS: num_points     <= pwdata[NUM_W-1:0];
        REG_EXP_SCALE:  exponent_scale <= pwdata;
        REG_NORM:       norm_factor    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_POINTS: prdata = CFG_W'(num_points);
      REG_EXP_SCALE:  prdata = exponent_scale;
      REG_NORM:       prdata = norm_factor;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (num_points == '0) n_eff = CNT_W'(1);
    else if (32'(num_points) > 32'(MAX_POINTS)) n_eff = CNT_W'(MAX_POINTS);
    else n_eff = CNT_W'(num_points);
  end

  gkde_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .n_eff(n_eff), .busy(busy), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  gkde_back #(.MAX_POINTS(MAX_POINTS), .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .n_eff(n_eff), .exponent_scale(exponent_scale),
    .norm_factor(norm_factor), .busy(busy), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .empty(empty), .pop(pop), .result(result)
  );

endmodule

// ----- src/gkde_ram.sv -----
module gkde_ram import gkde_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- src/gkde_front.sv -----
module gkde_front import gkde_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         request,
  input  logic [CNT_W-1:0] n_eff,
  input  logic             busy,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t               q [QDEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [PTR_W:0]     count;
  logic               accept;
  logic               keep;
  cmd_t               entry;

  assign full      = busy || (count == (PTR_W+1)'(QDEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rptr];

  always_comb begin
    entry.index = request.point_index;
    entry.point = {request.coord_z, request.coord_y, request.coord_x};
    keep        = 1'b1;
    if (request.mode == MODE_LOAD) begin
      entry.op = OP_LOAD;
      keep     = 32'(request.point_index) < 32'(MAX_POINTS);
    end else if (32'(request.point_index) >= 32'(n_eff)) begin
      entry.op = OP_BAD;
    end else begin
      entry.op = OP_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept && keep) begin
        q[wptr] <= entry;
        wptr    <= wptr + 1'b1;
      end
      if (cmd_pop && cmd_valid) rptr <= rptr + 1'b1;
      count <= count + (PTR_W+1)'(accept && keep) - (PTR_W+1)'(cmd_pop && cmd_valid);
    end
  end

endmodule

// ----- src/gkde_back.sv -----
module gkde_back import gkde_pkg::*; #(
  parameter int MAX_POINTS        = MAX_POINTS_DEF,
  parameter int EXP_TABLE_ENTRIES = EXP_ENTRIES_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] n_eff,
  input  logic [CFG_W-1:0] exponent_scale,
  input  logic [CFG_W-1:0] norm_factor,
  output logic             busy,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             empty,
  input  logic             pop,
  output out_item_t        result
);
`include "gaussian_kde_3d_assert.svh"

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int TW     = $clog2(EXP_TABLE_ENTRIES);
  localparam int SUM_W  = 33 + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int PT_W   = 3 * COORD_W;

  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREAD = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  typedef logic [32:0] tab_t [EXP_TABLE_ENTRIES];

  function automatic tab_t build_table();
    tab_t        t;
    logic [63:0] q;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      q    = (64'(i) << 32) / EXP_TABLE_ENTRIES;
      t[i] = exp_frac(q[31:0]);
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_table();

  logic [2:0]        state;
  logic [TW-1:0]     fill_cnt;
  logic [CNT_W-1:0]  issue_cnt;
  logic              issue;
  logic [3:0]        pv;
  logic [IDX_W-1:0]  q_index;
  logic [PT_W-1:0]   p_reg;
  logic [17:0]       d2_r;
  logic [49:0]       u_r;
  logic [5:0]        sh_r;
  logic              zero_r;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DCNT_W-1:0] div_cnt;
  logic [63:0]       prod_r;
  logic              hi_r;
  logic              out_valid;
  out_item_t         out_r;

  logic              pt_we;
  logic [PIDX_W-1:0] pt_waddr;
  logic [PIDX_W-1:0] pt_raddr;
  logic [PT_W-1:0]   pt_rdata;
  logic [TW-1:0]     tab_raddr;
  logic [32:0]       tab_rdata;
  logic [23+TW:0]    tprod;
  logic [17:0]       d2;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [65:0]       total;
  logic [49:0]       dens;

  gkde_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(cmd.point),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  gkde_ram #(.WIDTH(33), .DEPTH(EXP_TABLE_ENTRIES)) u_table (
    .clk(clk), .we(state == S_FILL), .waddr(fill_cnt), .wdata(EXP_TAB[fill_cnt]),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  assign busy   = (state == S_FILL);
  assign empty  = !out_valid;
  assign result = out_r;

  always_comb begin
    cmd_pop  = 1'b0;
    pt_we    = 1'b0;
    pt_waddr = PIDX_W'(cmd.index);
    pt_raddr = PIDX_W'(issue_cnt);
    issue    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_LOAD: begin
              cmd_pop = 1'b1;
              pt_we   = 1'b1;
            end
            OP_QUERY: begin
              cmd_pop  = 1'b1;
              pt_raddr = PIDX_W'(cmd.index);
            end
            OP_BAD:  cmd_pop = !out_valid;
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      S_RUN:   issue = 32'(issue_cnt) < 32'(n_eff);
      default: ;
    endcase
  end

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return 16'(d) * 16'(d);
  endfunction

  assign d2 = 18'(sq_diff(p_reg[7:0], pt_rdata[7:0]))
            + 18'(sq_diff(p_reg[15:8], pt_rdata[15:8]))
            + 18'(sq_diff(p_reg[23:16], pt_rdata[23:16]));

  assign tprod     = (24+TW)'(u_r[23:0]) * (24+TW)'(EXP_TABLE_ENTRIES);
  assign tab_raddr = tprod[24 +: TW];

  assign rem_sh = {rem_r, dvd_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, n_eff};

  assign total = 66'(prod_r) + (hi_r ? {2'b00, norm_factor, 32'd0} : 66'd0) + 66'd32768;
  assign dens  = total[65:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_cnt  <= '0;
      pv        <= '0;
      out_valid <= 1'b0;
    end else begin
      pv <= {pv[2:0], issue};
      if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (32'(fill_cnt) == EXP_TABLE_ENTRIES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd.op == OP_QUERY) begin
            q_index <= cmd.index;
            state   <= S_PREAD;
          end else if (cmd_valid && cmd.op == OP_BAD && !out_valid) begin
            out_valid <= 1'b1;
            out_r     <= '{queried_index: cmd.index, density: '0, bad_index: 1'b1};
          end
        end
        S_PREAD: begin
          p_reg     <= pt_rdata;
          issue_cnt <= '0;
          sum       <= '0;
          state     <= S_RUN;
        end
        S_RUN: begin
          if (issue) issue_cnt <= issue_cnt + 1'b1;
          if (pv[3] && !zero_r) sum <= sum + SUM_W'(tab_rdata >> sh_r);
          if (!issue && pv == '0) begin
            dvd_r   <= sum;
            rem_r   <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r   <= ge ? CNT_W'(rem_sh - {1'b0, n_eff}) : CNT_W'(rem_sh);
          dvd_r   <= {dvd_r[SUM_W-2:0], ge};
          div_cnt <= div_cnt + 1'b1;
          if (32'(div_cnt) == SUM_W - 1) state <= S_MUL;
        end
        S_MUL: begin
          prod_r <= 64'(dvd_r[31:0]) * 64'(norm_factor);
          hi_r   <= dvd_r[32];
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_r     <= '{queried_index: q_index,
                           density: (dens[49:48] != 2'b00) ? {DENS_W{1'b1}} : dens[47:0],
                           bad_index: 1'b0};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pv[0]) d2_r <= d2;
    if (pv[1]) u_r  <= 50'(d2_r) * 50'(exponent_scale);
    if (pv[2]) begin
      zero_r <= u_r[49:24] > 26'd32;
      sh_r   <= u_r[29:24];
    end
  end

  `GKDE_ASSERT_NOW(a_issue_bound, state == S_RUN, 32'(issue_cnt) <= 32'(n_eff), "issue past count")
  `GKDE_ASSERT_NOW(a_pipe_idle, state != S_RUN && state != S_DIV, pv == '0, "pipeline busy")
  `GKDE_ASSERT_NOW(a_mean_range, state == S_MUL, dvd_r[SUM_W-1:33] == '0, "mean overflow")
  `GKDE_ASSERT_NEXT(a_fill_done, state == S_IDLE, state != S_FILL, "table refill")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import gkde_pkg::*;

  localparam int NPTS  = MAX_POINTS_DEF;
  localparam int NEXP  = EXP_ENTRIES_DEF;
  localparam int LIMIT = 600000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  request = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0]   pwdata = '0;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  gaussian_kde_3d dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bit [63:0]  pow2_frac [NEXP];
  bit [23:0]  shadow_pts [NPTS];
  bit         written [NPTS];
  bit [12:0]  num_cfg;
  bit [31:0]  scale_cfg;
  bit [31:0]  norm_cfg;
  out_item_t  density_q [$];
  int         errors = 0;
  int         queries_done = 0;
  int         loads_done = 0;
  int         cycles = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         hold_cnt = 0;
  bit         hold_go = 0;
  bit         hold_seen = 0;

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic build_pow2_table();
    bit [63:0] roots [32];
    bit [63:0] q;
    bit [63:0] acc;
    roots[0] = floor_sqrt(64'd1 << 63);
    for (int k = 1; k < 32; k++) roots[k] = floor_sqrt(roots[k-1] << 32);
    for (int i = 0; i < NEXP; i++) begin
      q = (64'(i) << 32) / NEXP;
      acc = 64'd1 << 32;
      for (int k = 0; k < 32; k++)
        if (q[31-k]) acc = (acc * roots[k] + (64'd1 << 31)) >> 32;
      pow2_frac[i] = acc;
    end
  endtask

  function automatic int eff_count();
    if (num_cfg == 0) return 1;
    if (num_cfg > NPTS) return NPTS;
    return num_cfg;
  endfunction

  function automatic bit [63:0] kernel(bit [23:0] a, bit [23:0] b);
    bit [63:0] d2;
    bit [63:0] u;
    int d;
    d2 = 0;
    for (int s = 0; s < 24; s += 8) begin
      d = int'(a[s +: 8]) - int'(b[s +: 8]);
      d2 += 64'(d * d);
    end
    u = d2 * scale_cfg;
    if ((u >> 24) > 32) return 0;
    return pow2_frac[u[23:14]] >> (u >> 24);
  endfunction

  function automatic out_item_t density_at(bit [11:0] idx);
    out_item_t r;
    bit [63:0] sum;
    bit [79:0] dens;
    int n;
    n = eff_count();
    r.queried_index = idx;
    r.density = '0;
    r.bad_index = 1'b1;
    if (idx >= n) return r;
    sum = 0;
    for (int j = 0; j < n; j++) sum += kernel(shadow_pts[idx], shadow_pts[j]);
    dens = ((80'(sum / n) * norm_cfg) + (80'd1 << 15)) >> 16;
    r.density = (dens > 80'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : dens[47:0];
    r.bad_index = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("t=%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
    errors++;
  endtask

  // returns once the transaction is accepted; push stays high for the caller
  task automatic send(in_item_t it, bit typed = 0, out_item_t want = '0);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    request <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (it.mode == MODE_LOAD) begin
      shadow_pts[it.point_index] = {it.coord_z, it.coord_y, it.coord_x};
      written[it.point_index] = 1'b1;
      loads_done++;
    end else begin
      density_q.insert(density_q.size(), typed ? want : density_at(it.point_index));
      queries_done++;
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (density_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_sel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(reg_sel) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (reg_sel)
      REG_NUM_POINTS: num_cfg = value[12:0];
      REG_EXP_SCALE: scale_cfg = value;
      default: norm_cfg = value;
    endcase
  endtask

  task automatic configure(logic [31:0] n, logic [31:0] s, logic [31:0] m);
    apb_write(REG_NUM_POINTS, n);
    apb_write(REG_EXP_SCALE, s);
    apb_write(REG_NORM, m);
  endtask

  function automatic in_item_t mk(logic mode, int idx, int x, int y, int z);
    in_item_t it;
    it.mode = mode;
    it.point_index = idx[11:0];
    it.coord_x = x[7:0];
    it.coord_y = y[7:0];
    it.coord_z = z[7:0];
    return it;
  endfunction

  function automatic out_item_t bad_result(int idx);
    out_item_t r;
    r.queried_index = idx[11:0];
    r.density = '0;
    r.bad_index = 1'b1;
    return r;
  endfunction

  function automatic in_item_t rand_load(int idx, int base);
    return mk(MODE_LOAD, idx, (base + $urandom_range(40)) % 256,
              (base + $urandom_range(40)) % 256, (base + $urandom_range(40)) % 256);
  endfunction

  function automatic bit all_written(int n);
    for (int j = 0; j < n; j++) if (!written[j]) return 0;
    return 1;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      if (!rst && pop && !empty) begin
        if (density_q.size() == 0) begin
          report_mismatch("unexpected transaction, index", 0, result.queried_index);
        end else begin
          if (result.queried_index !== density_q[0].queried_index)
            report_mismatch("queried_index", density_q[0].queried_index, result.queried_index);
          if (result.density !== density_q[0].density)
            report_mismatch("density", density_q[0].density, result.density);
          if (result.bad_index !== density_q[0].bad_index)
            report_mismatch("bad_index", density_q[0].bad_index, result.bad_index);
          void'(density_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_go) begin
      hold_seen <= hold_go;
      hold_cnt <= 400;
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    stim_row_t rows [$];
    int n;
    int base;
    int r;
    int idx;

    build_pow2_table();
    num_cfg = NUM_POINTS_RST;
    scale_cfg = EXP_SCALE_RST;
    norm_cfg = NORM_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (full) @(posedge clk);

    configure(4, EXP_SCALE_RST, NORM_RST);
    rows.insert(rows.size(), '{mk(MODE_LOAD, 0, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_LOAD, 1, 255, 255, 255), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_LOAD, 2, 1, 2, 3), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_LOAD, 3, 0, 255, 0), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_LOAD, 4095, 255, 0, 255), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_LOAD, 4, 170, 85, 170), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 0, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 1, 255, 255, 255), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 2, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 3, 85, 170, 85), 0, '0});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 4, 0, 0, 0), 1, bad_result(4)});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 4095, 0, 0, 0), 1, bad_result(4095)});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 2048, 255, 255, 255), 1, bad_result(2048)});
    rows.insert(rows.size(), '{mk(MODE_QUERY, 1365, 0, 0, 0), 1, bad_result(1365)});
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // zero count acts as one, zero scale makes every kernel one
    configure(0, 0, 32'hFFFF_FFFF);
    send(mk(MODE_QUERY, 0, 0, 0, 0));
    send(mk(MODE_QUERY, 1, 0, 0, 0), 1, bad_result(1));
    send(mk(MODE_QUERY, 2730, 0, 0, 0), 1, bad_result(2730));
    drain();
    configure(3, 32'hFFFF_FFFF, 0);
    send(mk(MODE_QUERY, 1, 0, 0, 0));
    send(mk(MODE_QUERY, 2, 0, 0, 0));
    drain();

    for (int p = 0; p < 6; p++) begin
      gap_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 51 : 32) : 0;
      stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 51 : 32) : 0;
      n = $urandom_range(1, 24);
      base = $urandom_range(215);
      configure(n, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 26),
                $urandom);
      for (int j = 0; j < n; j++) if (!written[j] || $urandom_range(1)) send(rand_load(j, base));
      if (p == 1) begin
        hold_go = !hold_go;
        for (int j = 0; j < 12; j++) send(mk(MODE_QUERY, $urandom_range(n, 4095), 0, 0, 0));
      end
      for (int j = 0; j < 12; j++) begin
        r = $urandom_range(99);
        if (r < 50 && all_written(n)) begin
          send(mk(MODE_QUERY, $urandom_range(n - 1), $urandom, $urandom, $urandom));
        end else if (r < 70) begin
          send(mk(MODE_QUERY, $urandom_range(n, 4095), $urandom, $urandom, $urandom));
        end else if (r < 90) begin
          send(rand_load($urandom_range(n - 1), base));
        end else begin
          idx = $urandom_range(4095);
          send(mk(MODE_LOAD, idx, $urandom, $urandom, $urandom));
        end
      end
      drain();
    end

    if (density_q.size() != 0) report_mismatch("results left waiting", 0, density_q.size());
    $display("covered %0d loads and %0d queries across count, scale and norm extremes",
             loads_done, queries_done);
    $display("with idle and stall mixes, a long receiver hold-off and %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
